>>> sv/prim_mst_adjacency_matrix_unit_assert.svh
// Assertion macros shared by the spanning tree unit modules
`ifndef PRIM_MST_ADJACENCY_MATRIX_UNIT_ASSERT_SVH
`define PRIM_MST_ADJACENCY_MATRIX_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/prim_mst_pkg.sv
// Types, constants and codes of the spanning tree unit
package prim_mst_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int WEIGHT_BITS  = 16;

    localparam int VTX_W  = 6;
    localparam int WGT_W  = 16;
    localparam int CMD_W  = 2;
    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int ADJ_DEPTH = 1 << ADDR_W;
    localparam int KEY_W  = WEIGHT_BITS + 1;

    localparam logic [KEY_W-1:0] KEY_INF       = '1;
    localparam logic [VTX_W-1:0] VCOUNT_RESET  = VTX_W'(32);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_EDGE  = 2'd1,
        CMD_RUN   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic edge_first;
        logic edge_second;
        logic run_init;
        logic scan_step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic out_free;
        logic last_pick;
    } t_dp_sts;

endpackage

>>> sv/prim_mst_ram.sv
// Generic single write port, single read port RAM with registered read
module prim_mst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/prim_mst_ctrl.sv
// Sequencer for matrix clear, edge load and spanning tree runs
`include "prim_mst_adjacency_matrix_unit_assert.svh"

module prim_mst_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [prim_mst_pkg::CMD_W-1:0] i_command,
    input  prim_mst_pkg::t_dp_sts         i_sts,
    output prim_mst_pkg::t_dp_cmd         o_cmd
);

    prim_mst_pkg::t_state r_state;
    prim_mst_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prim_mst_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            prim_mst_pkg::ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = prim_mst_pkg::ST_IDLE;
                end
            end
            prim_mst_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (prim_mst_pkg::t_cmd'(i_command))
                        prim_mst_pkg::CMD_CLEAR: begin
                            n_state = prim_mst_pkg::ST_CLEAR;
                        end
                        prim_mst_pkg::CMD_EDGE: begin
                            o_cmd.edge_first = 1'b1;
                            n_state          = prim_mst_pkg::ST_EDGE;
                        end
                        prim_mst_pkg::CMD_RUN: begin
                            o_cmd.run_init = 1'b1;
                            n_state        = prim_mst_pkg::ST_SCAN;
                        end
                        default: begin
                            // undefined command: beat is dropped
                        end
                    endcase
                end
            end
            prim_mst_pkg::ST_EDGE: begin
                // mirror write of the symmetric entry
                o_cmd.edge_second = 1'b1;
                n_state           = prim_mst_pkg::ST_IDLE;
            end
            prim_mst_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = prim_mst_pkg::ST_EMIT;
                end
            end
            prim_mst_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.last_pick ? prim_mst_pkg::ST_IDLE
                                                 : prim_mst_pkg::ST_SCAN;
                end
            end
            default: begin
                n_state = prim_mst_pkg::ST_CLEAR;
            end
        endcase
    end

    `PM_ASSERT_NEXT(a_last_returns_idle, i_clk, i_rst_n, o_cmd.emit && i_sts.last_pick, r_state == prim_mst_pkg::ST_IDLE, "run did not end after last pick")
    `PM_ASSERT_NEXT(a_scan_stays_in_run, i_clk, i_rst_n, r_state == prim_mst_pkg::ST_SCAN, r_state == prim_mst_pkg::ST_SCAN || r_state == prim_mst_pkg::ST_EMIT, "scan left the run")
    `PM_ASSERT_NEXT(a_clear_done_ready, i_clk, i_rst_n, r_state == prim_mst_pkg::ST_CLEAR && i_sts.clear_done, o_in_ready, "not ready after clear sweep")

endmodule

>>> sv/prim_mst_dp.sv
// Datapath: adjacency memory, key/parent/visited arrays, scan and result register
`include "prim_mst_adjacency_matrix_unit_assert.svh"

module prim_mst_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  prim_mst_pkg::t_dp_cmd               i_cmd,
    output prim_mst_pkg::t_dp_sts               o_sts,
    input  logic                                i_cfg_valid,
    input  logic [prim_mst_pkg::VTX_W-1:0]      i_cfg_data,
    input  logic [prim_mst_pkg::VTX_W-1:0]      i_vertex_a,
    input  logic [prim_mst_pkg::VTX_W-1:0]      i_vertex_b,
    input  logic [prim_mst_pkg::WGT_W-1:0]      i_weight,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [prim_mst_pkg::VTX_W-1:0]      o_picked_vertex,
    output logic [prim_mst_pkg::VTX_W-1:0]      o_parent_vertex,
    output logic [prim_mst_pkg::WGT_W-1:0]      o_edge_weight,
    output logic                                o_unreachable,
    output logic                                o_last
);

    // configuration
    logic [prim_mst_pkg::VTX_W-1:0] r_vcount;
    logic [prim_mst_pkg::CNT_W-1:0] act_n;

    // adjacency memory port signals
    logic                                  ram_we;
    logic [prim_mst_pkg::ADDR_W-1:0]       ram_waddr;
    logic [prim_mst_pkg::WEIGHT_BITS-1:0]  ram_wdata;
    logic [prim_mst_pkg::ADDR_W-1:0]       ram_raddr;
    logic [prim_mst_pkg::WEIGHT_BITS-1:0]  ram_rdata;

    // clear sweep and edge load
    logic [prim_mst_pkg::ADDR_W-1:0]       r_clr_addr;
    logic [prim_mst_pkg::IDX_W-1:0]        a_idx, b_idx;
    logic                                  edge_ok;
    logic [prim_mst_pkg::IDX_W-1:0]        r_a_idx, r_b_idx;
    logic [prim_mst_pkg::WEIGHT_BITS-1:0]  r_w;
    logic                                  r_edge_ok;

    // scan control
    logic [prim_mst_pkg::CNT_W-1:0]        r_iss;
    logic                                  r_pv;
    logic [prim_mst_pkg::IDX_W-1:0]        r_pidx;
    logic [prim_mst_pkg::IDX_W-1:0]        r_prev_row;
    logic                                  r_relax_en;
    logic [prim_mst_pkg::CNT_W-1:0]        r_step;

    // per-vertex state
    logic [prim_mst_pkg::KEY_W-1:0]        r_key [prim_mst_pkg::MAX_VERTICES];
    logic [prim_mst_pkg::VTX_W-1:0]        r_par [prim_mst_pkg::MAX_VERTICES];
    logic [prim_mst_pkg::MAX_VERTICES-1:0] r_visited;

    // candidate tracking
    logic                                  r_cand_found;
    logic [prim_mst_pkg::KEY_W-1:0]        r_cand_key;
    logic [prim_mst_pkg::IDX_W-1:0]        r_cand_idx;
    logic [prim_mst_pkg::VTX_W-1:0]        r_cand_par;
    logic                                  r_low_found;
    logic [prim_mst_pkg::IDX_W-1:0]        r_low_idx;

    // per-entry processing
    logic                                  unvis;
    logic                                  relax;
    logic [prim_mst_pkg::KEY_W-1:0]        key_cur;
    logic [prim_mst_pkg::KEY_W-1:0]        key_new;
    logic [prim_mst_pkg::VTX_W-1:0]        par_new;

    // pick
    logic                                  lost;
    logic [prim_mst_pkg::IDX_W-1:0]        pick;

    // result register
    logic                                  r_out_valid;
    logic [prim_mst_pkg::VTX_W-1:0]        r_out_pick;
    logic [prim_mst_pkg::VTX_W-1:0]        r_out_par;
    logic [prim_mst_pkg::WGT_W-1:0]        r_out_wgt;
    logic                                  r_out_unr;
    logic                                  r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= prim_mst_pkg::VCOUNT_RESET;
        end else if (i_cfg_valid) begin
            r_vcount <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_vcount == '0) begin
            act_n = prim_mst_pkg::CNT_W'(1);
        end else if ((prim_mst_pkg::VTX_W + 1)'(r_vcount) >
                     (prim_mst_pkg::VTX_W + 1)'(prim_mst_pkg::MAX_VERTICES)) begin
            act_n = prim_mst_pkg::CNT_W'(prim_mst_pkg::MAX_VERTICES);
        end else begin
            act_n = prim_mst_pkg::CNT_W'(r_vcount);
        end
    end

    // edge endpoints outside 1..MAX_VERTICES drop the beat
    assign edge_ok =
        (i_vertex_a != '0) && (i_vertex_b != '0) &&
        ((prim_mst_pkg::VTX_W + 1)'(i_vertex_a) <=
         (prim_mst_pkg::VTX_W + 1)'(prim_mst_pkg::MAX_VERTICES)) &&
        ((prim_mst_pkg::VTX_W + 1)'(i_vertex_b) <=
         (prim_mst_pkg::VTX_W + 1)'(prim_mst_pkg::MAX_VERTICES));
    assign a_idx = prim_mst_pkg::IDX_W'(i_vertex_a - prim_mst_pkg::VTX_W'(1));
    assign b_idx = prim_mst_pkg::IDX_W'(i_vertex_b - prim_mst_pkg::VTX_W'(1));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr_addr;
        ram_wdata = '0;
        if (i_cmd.clear_step) begin
            ram_we = 1'b1;
        end else if (i_cmd.edge_first) begin
            ram_we    = edge_ok;
            ram_waddr = {a_idx, b_idx};
            ram_wdata = prim_mst_pkg::WEIGHT_BITS'(i_weight);
        end else if (i_cmd.edge_second) begin
            ram_we    = r_edge_ok;
            ram_waddr = {r_b_idx, r_a_idx};
            ram_wdata = r_w;
        end
    end

    // row of the previous pick, column of the entry being issued
    assign ram_raddr = {r_prev_row, r_iss[prim_mst_pkg::IDX_W-1:0]};

    prim_mst_ram #(
        .WIDTH(prim_mst_pkg::WEIGHT_BITS),
        .DEPTH(prim_mst_pkg::ADJ_DEPTH)
    ) u_adj_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            // wraps back to zero after the last entry
            r_clr_addr <= r_clr_addr + prim_mst_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_first) begin
            r_a_idx   <= a_idx;
            r_b_idx   <= b_idx;
            r_w       <= prim_mst_pkg::WEIGHT_BITS'(i_weight);
            r_edge_ok <= edge_ok;
        end
    end

    // one pass relaxes from the previous pick and searches the next one
    assign unvis   = !r_visited[r_pidx];
    assign key_cur = r_key[r_pidx];
    assign relax   = r_relax_en && (ram_rdata != '0) && unvis &&
                     ({1'b0, ram_rdata} < key_cur);
    assign key_new = relax ? {1'b0, ram_rdata} : key_cur;
    assign par_new = relax ? prim_mst_pkg::VTX_W'(r_prev_row) + prim_mst_pkg::VTX_W'(1)
                           : r_par[r_pidx];

    assign lost = !r_cand_found;
    assign pick = lost ? r_low_idx : r_cand_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss      <= '0;
            r_pv       <= 1'b0;
            r_step     <= '0;
            r_relax_en <= 1'b0;
        end else if (i_cmd.run_init || i_cmd.emit) begin
            r_iss      <= '0;
            r_pv       <= 1'b0;
            r_step     <= i_cmd.run_init ? '0 : r_step + prim_mst_pkg::CNT_W'(1);
            r_relax_en <= i_cmd.emit && !lost;
        end else if (i_cmd.scan_step) begin
            if (r_iss < act_n) begin
                r_iss <= r_iss + prim_mst_pkg::CNT_W'(1);
                r_pv  <= 1'b1;
            end else begin
                r_pv  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_iss[prim_mst_pkg::IDX_W-1:0];
        if (i_cmd.emit) begin
            r_prev_row <= pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_init) begin
            for (int i = 0; i < prim_mst_pkg::MAX_VERTICES; i++) begin
                r_key[i] <= prim_mst_pkg::KEY_INF;
                r_par[i] <= '0;
            end
            r_key[0] <= '0;
        end else if (r_pv) begin
            r_key[r_pidx] <= key_new;
            r_par[r_pidx] <= par_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
        end else if (i_cmd.run_init) begin
            r_visited <= '0;
        end else if (i_cmd.emit) begin
            r_visited[pick] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_found <= 1'b0;
            r_low_found  <= 1'b0;
            r_cand_key   <= prim_mst_pkg::KEY_INF;
        end else if (i_cmd.run_init || i_cmd.emit) begin
            r_cand_found <= 1'b0;
            r_low_found  <= 1'b0;
            r_cand_key   <= prim_mst_pkg::KEY_INF;
        end else if (r_pv && unvis) begin
            // strict compare keeps the lowest index on ties
            if (key_new < r_cand_key) begin
                r_cand_found <= 1'b1;
                r_cand_key   <= key_new;
                r_cand_idx   <= r_pidx;
                r_cand_par   <= par_new;
            end
            if (!r_low_found) begin
                r_low_found <= 1'b1;
                r_low_idx   <= r_pidx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_pick <= prim_mst_pkg::VTX_W'(pick) + prim_mst_pkg::VTX_W'(1);
            r_out_par  <= lost ? '0 : r_cand_par;
            r_out_wgt  <= lost ? '0
                               : prim_mst_pkg::WGT_W'(r_cand_key[prim_mst_pkg::WEIGHT_BITS-1:0]);
            r_out_unr  <= lost;
            r_out_last <= o_sts.last_pick;
        end
    end

    assign o_sts.clear_done = (r_clr_addr == '1);
    assign o_sts.scan_done  = (r_iss == act_n) && !r_pv;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_sts.last_pick  = (r_step + prim_mst_pkg::CNT_W'(1)) == act_n;

    assign o_out_valid     = r_out_valid;
    assign o_picked_vertex = r_out_pick;
    assign o_parent_vertex = r_out_par;
    assign o_edge_weight   = r_out_wgt;
    assign o_unreachable   = r_out_unr;
    assign o_last          = r_out_last;

    `PM_ASSERT_SAME(a_emit_has_pick, i_clk, i_rst_n, i_cmd.emit, r_cand_found || r_low_found, "emit with no unvisited vertex")
    `PM_ASSERT_NEXT(a_emit_marks_one, i_clk, i_rst_n, i_cmd.emit, $countones(r_visited) == $past($countones(r_visited)) + 1, "pick was already visited")
    `PM_ASSERT_NEXT(a_run_init_clean, i_clk, i_rst_n, i_cmd.run_init, r_visited == '0 && r_step == '0, "run did not start clean")

endmodule

>>> sv/prim_mst_adjacency_matrix_unit.sv
// Prim minimum spanning tree unit over a dense adjacency matrix: top level
// Items come in on the input channel; a run returns one result beat per vertex
// in use. A clear item sweeps the 1024-entry weight memory one entry per cycle
// (also right after reset, no input taken meanwhile); an edge item writes both
// directions in turn through the one write port. In a run, each of the n
// picks reads one row of the weight memory entry by entry (n reads through
// the registered read port, then the pass end is seen), relaxing keys from
// the previous pick while finding the next one, then emits the pick once the
// output register is free. The next item is taken as soon as the last result
// sits in the output register. The vertex count register may be written at
// any idle time; o_cfg_ready is always high.
module prim_mst_adjacency_matrix_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [prim_mst_pkg::VTX_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [prim_mst_pkg::CMD_W-1:0]      i_command,
    input  logic [prim_mst_pkg::VTX_W-1:0]      i_vertex_a,
    input  logic [prim_mst_pkg::VTX_W-1:0]      i_vertex_b,
    input  logic [prim_mst_pkg::WGT_W-1:0]      i_weight,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [prim_mst_pkg::VTX_W-1:0]      o_picked_vertex,
    output logic [prim_mst_pkg::VTX_W-1:0]      o_parent_vertex,
    output logic [prim_mst_pkg::WGT_W-1:0]      o_edge_weight,
    output logic                                o_unreachable,
    output logic                                o_last
);

    prim_mst_pkg::t_dp_cmd dp_cmd;
    prim_mst_pkg::t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    prim_mst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_command (i_command),
        .i_sts     (dp_sts),
        .o_cmd     (dp_cmd)
    );

    prim_mst_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_vertex_a     (i_vertex_a),
        .i_vertex_b     (i_vertex_b),
        .i_weight       (i_weight),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_picked_vertex(o_picked_vertex),
        .o_parent_vertex(o_parent_vertex),
        .o_edge_weight  (o_edge_weight),
        .o_unreachable  (o_unreachable),
        .o_last         (o_last)
    );

endmodule
